// ===== rtl/core/ray_uniform_grid_traversal_assert.svh =====
// Assertion macros shared by the grid traversal RTL.
`ifndef RAY_UNIFORM_GRID_TRAVERSAL_ASSERT_SVH
`define RAY_UNIFORM_GRID_TRAVERSAL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RUGT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RUGT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rugt_pkg.sv =====
// Shared types, constants and helpers for the grid traversal block.
`default_nettype none
package rugt_pkg;

	localparam int GRID_MAX    = 16;
	localparam int FRAC_BITS   = 16;
	localparam int MAX_RESULTS = 3 * GRID_MAX - 2;
	localparam int K_W         = $clog2(MAX_RESULTS);
	localparam int N_W         = 5;
	localparam int IDX_W       = 4;

	localparam logic signed [63:0] T_BIG    = 64'sh4000_0000_0000_0000;
	localparam logic [30:0]        EXIT_MAX = 31'h7FFF_FFFF;

	// Configuration register indexes
	localparam logic [2:0] REG_BOX_MIN_X    = 3'd0;
	localparam logic [2:0] REG_BOX_MIN_Y    = 3'd1;
	localparam logic [2:0] REG_BOX_MIN_Z    = 3'd2;
	localparam logic [2:0] REG_CELL_W_X     = 3'd3;
	localparam logic [2:0] REG_CELL_W_Y     = 3'd4;
	localparam logic [2:0] REG_CELL_W_Z     = 3'd5;
	localparam logic [2:0] REG_CELLS_PER_AX = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_WALK,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		OP_SLAB_LO,
		OP_SLAB_HI,
		OP_CHECK,
		OP_MUL,
		OP_IDX,
		OP_DT
	} op_t;

	// Request to the shared multiply/divide unit
	typedef struct packed {
		logic        start;
		logic        mul;
		logic [63:0] a;
		logic [63:0] b;
	} alu_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] result;
	} alu_rsp_t;

	// Clamp a ray parameter into the exit_t range
	function automatic logic [30:0] sat_exit(input logic signed [63:0] v);
		logic [30:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > 64'sd2147483647) begin
			r = EXIT_MAX;
		end else begin
			r = v[30:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ray_uniform_grid_traversal.sv =====
// Uniform grid ray traversal (3D DDA): sequencer, setup datapath and cell walker.
// Usage:
//   Configuration: cfg_we/cfg_index/cfg_data write the box corner, cell widths
//   and cells per axis; write only while in_ready is high and no result waits.
//   Input: one ray per beat on in_valid/in_ready (origin and direction, Q16.16).
//   Output: one beat per visited cell on out_valid/out_ready; the final beat
//   of a ray has last set. A ray missing the box gives one beat with missed.
//   One ray at a time: in_ready is high only when the block is idle.
//   Setup: runs on one shared multiply/divide unit; up to 12 divides and
//   3 multiplies per ray, and skipped axes (zero direction) shorten this.
//   Walk: each cell beat is computed, then held until the receiver takes it;
//   at most 46 beats per ray.
//   Stall: a held result stays on the outputs, and the walk waits, until
//   out_ready is seen.
//   Reset: asynchronous, returns to idle and loads register defaults
//   (box at origin, unit cells, 16 cells per axis).
`default_nettype none
module ray_uniform_grid_traversal (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] origin_x,
	input  wire logic signed [31:0] origin_y,
	input  wire logic signed [31:0] origin_z,
	input  wire logic signed [31:0] dir_x,
	input  wire logic signed [31:0] dir_y,
	input  wire logic signed [31:0] dir_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [3:0]              cell_x,
	output logic [3:0]              cell_y,
	output logic [3:0]              cell_z,
	output logic [30:0]             exit_t,
	output logic                    missed,
	output logic                    last
);

	rugt_pkg::state_t state_q, state_d;
	rugt_pkg::op_t    op_q, op_next;
	logic [1:0]       axis_q, axis_next;
	logic [rugt_pkg::K_W-1:0] k_q;

	// configuration
	logic signed [31:0] box_min_q [3];
	logic [30:0]        cw_q [3];
	logic [4:0]         cpa_q;

	// per-ray state
	logic signed [31:0] o_q [3];
	logic signed [31:0] d_q [3];
	logic signed [63:0] lo_q [3];
	logic signed [63:0] nxt_q [3];
	logic [47:0]        dt_q [3];
	logic [rugt_pkg::IDX_W-1:0] idx_q [3];
	logic signed [63:0] tmin_q, tmax_q, p_q;
	logic               miss_q;

	// result register
	logic [3:0]  cell_x_q, cell_y_q, cell_z_q;
	logic [30:0] exit_t_q;
	logic        missed_q, last_q;

	rugt_pkg::alu_req_t alu_req;
	rugt_pkg::alu_rsp_t alu_rsp;

	rugt_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// effective registers
	logic [rugt_pkg::N_W-1:0] n_eff;
	logic [30:0]              cw_eff;
	always_comb begin
		if (cpa_q == '0) begin
			n_eff = rugt_pkg::N_W'(1);
		end else if (int'(cpa_q) > rugt_pkg::GRID_MAX) begin
			n_eff = rugt_pkg::N_W'(rugt_pkg::GRID_MAX);
		end else begin
			n_eff = cpa_q;
		end
		cw_eff = (cw_q[axis_q] == '0) ? 31'd1 : cw_q[axis_q];
	end

	// setup arithmetic for the current axis
	logic signed [63:0] o_a, d_a, bmin_a, bmax_a, num_lo, num_hi, num_sel, rel, q_signed;
	logic [35:0]  span;
	logic [63:0]  num_mag, d_mag, quot, off;
	logic         num_neg, d_neg, d_zero;
	logic [3:0]   idx_clamp;
	logic [4:0]   factor;
	logic [52:0]  step_prod;
	logic signed [63:0] nxt_new;
	logic         need_unit, finish, miss_now;

	always_comb begin
		o_a     = 64'(o_q[axis_q]);
		d_a     = 64'(d_q[axis_q]);
		d_zero  = (d_q[axis_q] == '0);
		d_neg   = d_q[axis_q][31];
		d_mag   = d_neg ? 64'(-d_a) : 64'(d_a);
		bmin_a  = 64'(box_min_q[axis_q]);
		span    = 36'(n_eff) * 36'(cw_eff);
		bmax_a  = bmin_a + signed'(64'(span));
		num_lo  = (bmin_a - o_a) <<< rugt_pkg::FRAC_BITS;
		num_hi  = (bmax_a - o_a) <<< rugt_pkg::FRAC_BITS;
		num_sel = (op_q == rugt_pkg::OP_SLAB_LO) ? num_lo : num_hi;
		num_neg = num_sel[63];
		num_mag = num_neg ? 64'(-num_sel) : 64'(num_sel);
		quot    = alu_rsp.result;
		q_signed = (num_neg ^ d_neg) ? -signed'(quot) : signed'(quot);
		off     = quot >> rugt_pkg::FRAC_BITS;
		rel     = p_q - bmin_a;
		idx_clamp = (quot > 64'(n_eff - 5'd1)) ? 4'(n_eff - 5'd1) : quot[3:0];
		factor  = d_neg ? (n_eff - 5'(idx_q[axis_q])) : (5'(idx_q[axis_q]) + 5'd1);
		step_prod = 53'(factor) * 53'(quot[47:0]);
		nxt_new = lo_q[axis_q] + signed'(64'(step_prod));
		miss_now = miss_q || (tmin_q > tmax_q) || (tmax_q < 0);
	end

	// does the current op use the shared unit
	always_comb begin
		need_unit = 1'b0;
		case (op_q)
			rugt_pkg::OP_SLAB_LO, rugt_pkg::OP_SLAB_HI: need_unit = !d_zero;
			rugt_pkg::OP_MUL: need_unit = (tmin_q > 0) && !d_zero;
			rugt_pkg::OP_IDX: need_unit = !rel[63];
			rugt_pkg::OP_DT:  need_unit = !d_zero;
			default:          need_unit = 1'b0;
		endcase
		finish = ((state_q == rugt_pkg::ST_ISSUE) && !need_unit)
			|| ((state_q == rugt_pkg::ST_WAIT) && alu_rsp.done);
	end

	// op sequence
	always_comb begin
		op_next   = op_q;
		axis_next = axis_q;
		unique case (op_q)
			rugt_pkg::OP_SLAB_LO: op_next = rugt_pkg::OP_SLAB_HI;
			rugt_pkg::OP_SLAB_HI: begin
				if (axis_q == 2'd2) begin
					op_next   = rugt_pkg::OP_CHECK;
					axis_next = 2'd0;
				end else begin
					op_next   = rugt_pkg::OP_SLAB_LO;
					axis_next = axis_q + 2'd1;
				end
			end
			rugt_pkg::OP_CHECK: op_next = rugt_pkg::OP_MUL;
			rugt_pkg::OP_MUL:   op_next = rugt_pkg::OP_IDX;
			rugt_pkg::OP_IDX:   op_next = rugt_pkg::OP_DT;
			rugt_pkg::OP_DT: begin
				op_next   = rugt_pkg::OP_MUL;
				axis_next = axis_q + 2'd1;
			end
			default: op_next = op_q;
		endcase
	end

	// walk step choice
	logic       all_zero, walk_last;
	logic [1:0] ax;
	logic signed [5:0] ni;
	always_comb begin
		all_zero = (d_q[0] == '0) && (d_q[1] == '0) && (d_q[2] == '0);
		if ((nxt_q[0] < nxt_q[1]) && (nxt_q[0] < nxt_q[2])) begin
			ax = 2'd0;
		end else if (nxt_q[1] < nxt_q[2]) begin
			ax = 2'd1;
		end else begin
			ax = 2'd2;
		end
		ni = d_q[ax][31] ? (signed'(6'(idx_q[ax])) - 6'sd1)
			: (signed'(6'(idx_q[ax])) + 6'sd1);
		walk_last = all_zero || ni[5] || (6'(ni) >= 6'(n_eff))
			|| (k_q == rugt_pkg::K_W'(rugt_pkg::MAX_RESULTS - 1));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rugt_pkg::ST_IDLE: if (in_valid) state_d = rugt_pkg::ST_ISSUE;
			rugt_pkg::ST_ISSUE: begin
				if (op_q == rugt_pkg::OP_CHECK) begin
					state_d = miss_now ? rugt_pkg::ST_EMIT : rugt_pkg::ST_ISSUE;
				end else if (need_unit) begin
					state_d = rugt_pkg::ST_WAIT;
				end else if (op_q == rugt_pkg::OP_DT && axis_q == 2'd2) begin
					state_d = rugt_pkg::ST_WALK;
				end
			end
			rugt_pkg::ST_WAIT: begin
				if (alu_rsp.done) begin
					state_d = (op_q == rugt_pkg::OP_DT && axis_q == 2'd2)
						? rugt_pkg::ST_WALK : rugt_pkg::ST_ISSUE;
				end
			end
			rugt_pkg::ST_WALK: state_d = rugt_pkg::ST_EMIT;
			rugt_pkg::ST_EMIT: begin
				if (out_ready) state_d = last_q ? rugt_pkg::ST_IDLE : rugt_pkg::ST_WALK;
			end
			default: state_d = rugt_pkg::ST_IDLE;
		endcase
	end

	// outputs and unit request
	always_comb begin
		in_ready      = (state_q == rugt_pkg::ST_IDLE);
		out_valid     = (state_q == rugt_pkg::ST_EMIT);
		alu_req.start = (state_q == rugt_pkg::ST_ISSUE) && need_unit;
		alu_req.mul   = (op_q == rugt_pkg::OP_MUL);
		case (op_q)
			rugt_pkg::OP_MUL: begin
				alu_req.a = 64'(tmin_q);
				alu_req.b = d_mag;
			end
			rugt_pkg::OP_IDX: begin
				alu_req.a = 64'(rel);
				alu_req.b = 64'(cw_eff);
			end
			rugt_pkg::OP_DT: begin
				alu_req.a = 64'(cw_eff) << rugt_pkg::FRAC_BITS;
				alu_req.b = d_mag;
			end
			default: begin
				alu_req.a = num_mag;
				alu_req.b = d_mag;
			end
		endcase
	end

	// control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rugt_pkg::ST_IDLE;
			op_q    <= rugt_pkg::OP_SLAB_LO;
			axis_q  <= '0;
			k_q     <= '0;
			for (int i = 0; i < 3; i++) begin
				box_min_q[i] <= '0;
				cw_q[i]      <= 31'd65536;
			end
			cpa_q <= 5'd16;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				op_q   <= rugt_pkg::OP_SLAB_LO;
				axis_q <= '0;
				k_q    <= '0;
			end else if (finish) begin
				op_q   <= op_next;
				axis_q <= axis_next;
			end else if (state_q == rugt_pkg::ST_WALK) begin
				k_q <= k_q + rugt_pkg::K_W'(1);
			end
			if (cfg_we) begin
				case (cfg_index)
					rugt_pkg::REG_BOX_MIN_X:    box_min_q[0] <= cfg_data;
					rugt_pkg::REG_BOX_MIN_Y:    box_min_q[1] <= cfg_data;
					rugt_pkg::REG_BOX_MIN_Z:    box_min_q[2] <= cfg_data;
					rugt_pkg::REG_CELL_W_X:     cw_q[0] <= cfg_data[30:0];
					rugt_pkg::REG_CELL_W_Y:     cw_q[1] <= cfg_data[30:0];
					rugt_pkg::REG_CELL_W_Z:     cw_q[2] <= cfg_data[30:0];
					rugt_pkg::REG_CELLS_PER_AX: cpa_q <= cfg_data[4:0];
					default: ;
				endcase
			end
		end
	end

	// ray datapath
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			o_q[0] <= origin_x;
			o_q[1] <= origin_y;
			o_q[2] <= origin_z;
			d_q[0] <= dir_x;
			d_q[1] <= dir_y;
			d_q[2] <= dir_z;
			for (int i = 0; i < 3; i++) lo_q[i] <= '0;
			tmin_q <= -rugt_pkg::T_BIG;
			tmax_q <= rugt_pkg::T_BIG;
			miss_q <= 1'b0;
		end else if (finish) begin
			case (op_q)
				rugt_pkg::OP_SLAB_LO: begin
					if (d_zero) begin
						if ((o_a < bmin_a) || (o_a > bmax_a)) miss_q <= 1'b1;
					end else if (!d_neg) begin
						lo_q[axis_q] <= q_signed;
						if (q_signed > tmin_q) tmin_q <= q_signed;
					end else begin
						if (q_signed < tmax_q) tmax_q <= q_signed;
					end
				end
				rugt_pkg::OP_SLAB_HI: begin
					if (!d_zero) begin
						if (!d_neg) begin
							if (q_signed < tmax_q) tmax_q <= q_signed;
						end else begin
							lo_q[axis_q] <= q_signed;
							if (q_signed > tmin_q) tmin_q <= q_signed;
						end
					end
				end
				rugt_pkg::OP_CHECK: begin
					// miss result: zero cell, last
					cell_x_q <= '0;
					cell_y_q <= '0;
					cell_z_q <= '0;
					exit_t_q <= '0;
					missed_q <= 1'b1;
					last_q   <= 1'b1;
				end
				rugt_pkg::OP_MUL: begin
					if (need_unit) begin
						p_q <= d_neg ? (o_a - signed'(off)) : (o_a + signed'(off));
					end else begin
						p_q <= o_a;
					end
				end
				rugt_pkg::OP_IDX: idx_q[axis_q] <= need_unit ? idx_clamp : '0;
				rugt_pkg::OP_DT: begin
					if (need_unit) begin
						dt_q[axis_q]  <= quot[47:0];
						nxt_q[axis_q] <= nxt_new;
					end else begin
						dt_q[axis_q]  <= '0;
						nxt_q[axis_q] <= rugt_pkg::T_BIG;
					end
				end
				default: ;
			endcase
		end else if (state_q == rugt_pkg::ST_WALK) begin
			// present current cell, then step
			cell_x_q <= idx_q[0];
			cell_y_q <= idx_q[1];
			cell_z_q <= idx_q[2];
			exit_t_q <= all_zero ? rugt_pkg::EXIT_MAX : rugt_pkg::sat_exit(nxt_q[ax]);
			missed_q <= 1'b0;
			last_q   <= walk_last;
			if (!walk_last) begin
				nxt_q[ax] <= nxt_q[ax] + signed'(64'(dt_q[ax]));
				idx_q[ax] <= ni[3:0];
			end
		end
	end

	assign cell_x = cell_x_q;
	assign cell_y = cell_y_q;
	assign cell_z = cell_z_q;
	assign exit_t = exit_t_q;
	assign missed = missed_q;
	assign last   = last_q;

	`include "ray_uniform_grid_traversal_assert.svh"

	`RUGT_ASSERT_NOW(a_miss_form, out_valid && missed, last && cell_x == 4'd0 && cell_y == 4'd0 && cell_z == 4'd0 && exit_t == 31'd0, "missed beat not a zero last beat")
	`RUGT_ASSERT_NOW(a_one_ray, in_ready, !out_valid, "result shown while idle")
	`RUGT_ASSERT_NEXT(a_last_idle, out_valid && out_ready && last, in_ready, "not idle after last beat")
	`RUGT_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready && !out_valid, "ray not taken into setup")

endmodule
`default_nettype wire

// ===== rtl/core/rugt_alu.sv =====
// Shared iterative unit: unsigned 64/64 restoring divide or 64x32 shift-add multiply.
`default_nettype none
module rugt_alu (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rugt_pkg::alu_req_t req,
	output rugt_pkg::alu_rsp_t      rsp
);

	logic        busy_q;
	logic        done_q;
	logic        mul_q;
	logic [6:0]  cnt_q;
	logic [64:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] opa_q;
	logic [63:0] opb_q;

	logic [64:0] rem_sh;
	logic        ge;

	// one quotient bit per cycle
	always_comb begin
		rem_sh = {rem_q[63:0], quo_q[63]};
		ge     = (rem_sh >= {1'b0, opb_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.mul ? 7'd32 : 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			mul_q <= req.mul;
			opa_q <= req.a;
			opb_q <= req.b;
			rem_q <= '0;
			quo_q <= req.mul ? 64'd0 : req.a;
		end else if (busy_q) begin
			if (mul_q) begin
				quo_q <= {quo_q[62:0], 1'b0} + (opb_q[31] ? opa_q : 64'd0);
				opb_q <= {opb_q[62:0], 1'b0};
			end else begin
				rem_q <= ge ? (rem_sh - {1'b0, opb_q}) : rem_sh;
				quo_q <= {quo_q[62:0], ge};
			end
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = quo_q;

endmodule
`default_nettype wire
